@@ hw/rtl/clpc_pkg.sv @@
`default_nettype none
package clpc_pkg;
   localparam int MAX_CHANNELS_DEF = 8;
   localparam int SAMPLE_BITS      = 24;
   localparam int CH_CNT_W         = 4;
   localparam int COEF_W           = 24;
   localparam int IRATIO_W         = 17;
   localparam int GAIN_W           = 24;
   localparam int FGAIN_W          = 33;
   localparam int DIV_Q_W          = 24;
   localparam int DIV_N_W          = 48;

   localparam logic [2:0] REG_ENABLE   = 3'd0;
   localparam logic [2:0] REG_CH_COUNT = 3'd1;
   localparam logic [2:0] REG_THRESH   = 3'd2;
   localparam logic [2:0] REG_IRATIO   = 3'd3;
   localparam logic [2:0] REG_ATTACK   = 3'd4;
   localparam logic [2:0] REG_RELEASE  = 3'd5;
   localparam logic [2:0] REG_SMOOTH   = 3'd6;
   localparam logic [2:0] REG_MAKEUP   = 3'd7;

   localparam logic [23:0] UNITY_Q23 = 24'd8388608;
   localparam logic [16:0] UNITY_Q16 = 17'd65536;

   typedef struct packed {
      logic        enable;
      logic [3:0]  channel_count;
      logic [23:0] threshold;
      logic [16:0] inv_ratio;
      logic [23:0] attack_coef;
      logic [23:0] release_coef;
      logic [23:0] smooth_coef;
      logic [23:0] makeup_gain;
   } cfg_type;

   // one-pole: (c*y + (2^24-c)*x + 2^23) >> 24
   function automatic logic [23:0] one_pole(input logic [23:0] c, input logic [23:0] y,
                                            input logic [23:0] x);
      logic [49:0] acc;
      acc = 50'(c) * 50'(y) + (50'h1000000 - 50'(c)) * 50'(x) + 50'h800000;
      return acc[47:24];
   endfunction
endpackage
`default_nettype wire

@@ hw/rtl/channel_linked_peak_compressor.sv @@
`default_nettype none
// channel   dir  handshake              payload
// req_      in   req_tvalid/req_tready   samples ch0..ch7, tlast
// rsp_      out  rsp_tvalid/rsp_tready   gained samples ch0..ch7, tlast
// csr_      in   csr_we                  index, data
// One request at a time; req_tready is high only in idle. With the envelope above the
// threshold the request passes peak, envelope, the 48-step restoring divide (start and
// done flag included), smoothing, gain and output; at or below it the divide is skipped,
// and in bypass it goes straight to output. The block then returns to idle for the next.
// Reset is synchronous and needs no clearing pass. The result register holds while
// rsp_tready is low, and a full result register holds the next request in the output step.
module channel_linked_peak_compressor
   import clpc_pkg::*;
#(
   parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic      req_tready,
   // sample_ch0 .. sample_chN-1, lowest first
   input  wire logic [((MAX_CHANNELS*SAMPLE_BITS+7)/8)*8-1:0] req_tdata,
   input  wire logic req_tlast,
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   // out_ch0 .. out_chN-1, lowest first
   output logic [((MAX_CHANNELS*SAMPLE_BITS+7)/8)*8-1:0] rsp_tdata,
   output logic      rsp_tlast,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [23:0] csr_data
);
   localparam int DW = ((MAX_CHANNELS*SAMPLE_BITS+7)/8)*8;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_PEAK  = 7'b0000010,
      S_ENV   = 7'b0000100,
      S_DIV   = 7'b0001000,
      S_GAIN  = 7'b0010000,
      S_SCALE = 7'b0100000,
      S_OUT   = 7'b1000000
   } state_type;

   cfg_type cfg_ff;
   state_type st_ff, st_in;
   logic [23:0] env_ff, env_in;
   logic [23:0] sg_ff, sg_in;
   logic [23:0] target_ff, target_in;
   logic [FGAIN_W-1:0] fgain_ff, fgain_in;
   logic [23:0] peak_ff, peak_in;
   logic signed [SAMPLE_BITS-1:0] smp_ff [MAX_CHANNELS];
   logic last_ff;
   logic out_v_ff, out_v_in;
   logic [DW-1:0] out_d_ff, out_d_in;
   logic out_l_ff;
   logic [3:0] n_act;
   logic [SAMPLE_BITS-1:0] mags [MAX_CHANNELS];
   logic [SAMPLE_BITS-1:0] res  [MAX_CHANNELS];
   logic [SAMPLE_BITS-1:0] pk;
   logic        div_start;
   logic        div_done;
   logic        div_run_ff;
   logic [23:0] div_q;
   logic [DIV_N_W-1:0] numer;
   logic [16:0] ir;
   logic [23:0] env_step;
   logic [23:0] sg_step;
   logic [47:0] fg_prod;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{enable: 1'b1, channel_count: 4'd2, threshold: 24'd838861,
                     inv_ratio: 17'd16384, attack_coef: 24'd16765569,
                     release_coef: 24'd16775468, smooth_coef: 24'd16765569,
                     makeup_gain: 24'd65536};
      end else if (csr_we) begin
         unique case (csr_index)
            REG_ENABLE:   cfg_ff.enable        <= csr_data[0];
            REG_CH_COUNT: cfg_ff.channel_count <= csr_data[3:0];
            REG_THRESH:   cfg_ff.threshold     <= csr_data;
            REG_IRATIO:   cfg_ff.inv_ratio     <= csr_data[16:0];
            REG_ATTACK:   cfg_ff.attack_coef   <= csr_data;
            REG_RELEASE:  cfg_ff.release_coef  <= csr_data;
            REG_SMOOTH:   cfg_ff.smooth_coef   <= csr_data;
            REG_MAKEUP:   cfg_ff.makeup_gain   <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (cfg_ff.channel_count == 4'd0) n_act = 4'd1;
      else if (32'(cfg_ff.channel_count) > MAX_CHANNELS) n_act = 4'(MAX_CHANNELS);
      else n_act = cfg_ff.channel_count;
   end

   for (genvar g = 0; g < MAX_CHANNELS; g++) begin : g_lane
      clpc_lane u_lane (
         .active (32'(g) < 32'(n_act)),
         .enable (cfg_ff.enable),
         .sample (smp_ff[g]),
         .fgain  (fgain_ff),
         .mag    (mags[g]),
         .result (res[g])
      );
   end

   // merge: peak over lanes
   always_comb begin
      pk = '0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
         if (mags[i] > pk) pk = mags[i];
      end
   end

   assign ir       = (cfg_ff.inv_ratio > UNITY_Q16) ? UNITY_Q16 : cfg_ff.inv_ratio;
   assign numer    = ((48'(cfg_ff.threshold) << 16) +
                      48'(env_ff - cfg_ff.threshold) * 48'(ir)) << 7;
   assign env_step = (peak_ff > env_ff) ? one_pole(cfg_ff.attack_coef, env_ff, peak_ff)
                                        : one_pole(cfg_ff.release_coef, env_ff, peak_ff);
   assign sg_step  = one_pole(cfg_ff.smooth_coef, sg_ff, target_ff);
   assign fg_prod  = 48'(sg_ff) * 48'(cfg_ff.makeup_gain) + 48'h8000;

   clpc_divider u_div (
      .clock (clock), .reset (reset), .start (div_start),
      .numer (numer), .denom (env_ff), .done (div_done), .quot (div_q)
   );

   always_comb begin
      out_d_in = '0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
         out_d_in[i*SAMPLE_BITS +: SAMPLE_BITS] = res[i];
      end
   end

   assign req_tready = (st_ff == S_IDLE);

   always_comb begin
      st_in     = st_ff;
      env_in    = env_ff;
      sg_in     = sg_ff;
      target_in = target_ff;
      fgain_in  = fgain_ff;
      peak_in   = peak_ff;
      out_v_in  = out_v_ff;
      div_start = 1'b0;
      if (out_v_ff && rsp_tready) out_v_in = 1'b0;
      unique case (st_ff)
         S_IDLE: if (req_tvalid) st_in = cfg_ff.enable ? S_PEAK : S_OUT;
         S_PEAK: begin
            peak_in = pk;
            st_in   = S_ENV;
         end
         S_ENV: begin
            env_in = env_step;
            if (env_step > cfg_ff.threshold) begin
               st_in = S_DIV;
            end else begin
               target_in = UNITY_Q23;
               st_in     = S_GAIN;
            end
         end
         S_DIV: begin
            // start once on the updated envelope, then wait for the quotient
            if (!div_run_ff) div_start = 1'b1;
            if (div_done) begin
               target_in = div_q;
               st_in     = S_GAIN;
            end
         end
         S_GAIN: begin
            sg_in = sg_step;
            st_in = S_SCALE;
         end
         S_SCALE: begin
            fgain_in = FGAIN_W'(fg_prod >> 16);
            st_in    = S_OUT;
         end
         S_OUT: begin
            if (!out_v_ff || rsp_tready) begin
               out_v_in = 1'b1;
               st_in    = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff      <= S_IDLE;
         env_ff     <= '0;
         sg_ff      <= UNITY_Q23;
         out_v_ff   <= 1'b0;
         div_run_ff <= 1'b0;
      end else begin
         st_ff    <= st_in;
         env_ff   <= env_in;
         sg_ff    <= sg_in;
         out_v_ff <= out_v_in;
         if (div_start) div_run_ff <= 1'b1;
         else if (div_done) div_run_ff <= 1'b0;
      end
      target_ff <= target_in;
      peak_ff   <= peak_in;
      fgain_ff  <= fgain_in;
      if (req_tvalid && req_tready) begin
         for (int i = 0; i < MAX_CHANNELS; i++) begin
            smp_ff[i] <= req_tdata[i*SAMPLE_BITS +: SAMPLE_BITS];
         end
         last_ff <= req_tlast;
      end
      if (st_ff == S_OUT && (!out_v_ff || rsp_tready)) begin
         out_d_ff <= out_d_in;
         out_l_ff <= last_ff;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_d_ff;
   assign rsp_tlast  = out_l_ff;

   a_one_hot: assert property (@(posedge clock) disable iff (reset) $onehot(st_ff))
      else $error("state not one-hot");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (st_ff != S_IDLE) |-> !req_tready) else $error("ready while busy");
   a_env_range: assert property (@(posedge clock) disable iff (reset)
      env_ff <= UNITY_Q23) else $error("envelope over full scale");
endmodule
`default_nettype wire

@@ hw/rtl/clpc_lane.sv @@
`default_nettype none
module clpc_lane
   import clpc_pkg::*;
(
   input  wire logic                          active,
   input  wire logic                          enable,
   input  wire logic signed [SAMPLE_BITS-1:0] sample,
   input  wire logic [FGAIN_W-1:0]            fgain,
   output logic [SAMPLE_BITS-1:0]             mag,
   output logic [SAMPLE_BITS-1:0]             result
);
   localparam int PW = SAMPLE_BITS + FGAIN_W;
   logic              neg;
   logic [PW-1:0]     prod;
   logic [PW-1:0]     r;
   logic [SAMPLE_BITS-1:0] maxp;
   logic [SAMPLE_BITS-1:0] minmag;

   assign neg    = sample[SAMPLE_BITS-1];
   assign mag    = !active ? '0 : (neg ? SAMPLE_BITS'(-sample) : SAMPLE_BITS'(sample));
   assign maxp   = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   assign minmag = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   assign prod   = PW'(mag) * PW'(fgain);
   assign r      = (prod + (PW'(1) << (SAMPLE_BITS-2))) >> (SAMPLE_BITS-1);

   always_comb begin
      if (!active) begin
         result = '0;
      end else if (!enable) begin
         result = sample;
      end else if (neg) begin
         result = (r > PW'(minmag)) ? minmag : SAMPLE_BITS'(-r);
      end else begin
         result = (r > PW'(maxp)) ? maxp : SAMPLE_BITS'(r);
      end
   end
endmodule
`default_nettype wire

@@ hw/rtl/clpc_divider.sv @@
`default_nettype none
module clpc_divider
   import clpc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [DIV_N_W-1:0] numer,
   input  wire logic [23:0]        denom,
   output logic                    done,
   output logic [DIV_Q_W-1:0]      quot
);
   // restoring divider, one quotient bit per cycle; quotient fits in 24 bits
   logic [DIV_N_W-1:0] num_ff, num_in;
   logic [24:0]        rem_ff, rem_in;
   logic [DIV_Q_W-1:0] q_ff, q_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [25:0]        trial;

   assign trial = {rem_ff, num_ff[DIV_N_W-1]};

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = numer;
         rem_in  = '0;
         cnt_in  = 6'(DIV_N_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = num_ff << 1;
         if (trial >= 26'(denom)) begin
            rem_in = 25'(trial - 26'(denom));
            q_in   = {q_ff[DIV_Q_W-2:0], 1'b1};
         end else begin
            rem_in = trial[24:0];
            q_in   = {q_ff[DIV_Q_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

   assign done = done_ff;
   assign quot = q_ff;
endmodule
`default_nettype wire

@@ dv/tb_channel_linked_peak_compressor.sv @@
`timescale 1ns / 100ps
`default_nettype none

class frame_scoreboard;
   logic [191:0] gained_q[$];
   logic         last_q[$];
   int           errors;

   // predictor state and registers
   logic         en;
   logic [3:0]   ch_count;
   logic [23:0]  thresh;
   logic [16:0]  iratio;
   logic [23:0]  attack, release_c, smooth, makeup;
   logic [23:0]  env, sgain;

   function void reset_state();
      en = 1'b1; ch_count = 4'd2; thresh = 24'd838861; iratio = 17'd16384;
      attack = 24'd16765569; release_c = 24'd16775468; smooth = 24'd16765569;
      makeup = 24'd65536;
      env = '0; sgain = 24'd8388608;
      errors = 0;
   endfunction

   function void write_reg(logic [2:0] idx, logic [23:0] val);
      case (idx)
         clpc_pkg::REG_ENABLE:   en = val[0];
         clpc_pkg::REG_CH_COUNT: ch_count = val[3:0];
         clpc_pkg::REG_THRESH:   thresh = val;
         clpc_pkg::REG_IRATIO:   iratio = val[16:0];
         clpc_pkg::REG_ATTACK:   attack = val;
         clpc_pkg::REG_RELEASE:  release_c = val;
         clpc_pkg::REG_SMOOTH:   smooth = val;
         clpc_pkg::REG_MAKEUP:   makeup = val;
         default: ;
      endcase
   endfunction

   function logic [23:0] lowpass(logic [23:0] c, logic [23:0] y, logic [23:0] x);
      logic [63:0] acc;
      acc = 64'(c) * 64'(y) + (64'd16777216 - 64'(c)) * 64'(x) + 64'd8388608;
      return acc[47:24];
   endfunction

   function void note_request(logic [191:0] smp, logic lst);
      int n;
      logic [191:0] o;
      logic [23:0] peak, tgt, mag;
      logic signed [23:0] s;
      logic [63:0] num, ir, fgain, r;
      n = (ch_count == 4'd0) ? 1 : (ch_count > 4'd8) ? 8 : int'(ch_count);
      o = '0;
      if (!en) begin
         for (int c = 0; c < n; c++) o[c*24 +: 24] = smp[c*24 +: 24];
      end else begin
         peak = '0;
         for (int c = 0; c < n; c++) begin
            s = smp[c*24 +: 24];
            mag = s < 0 ? -s : s;
            if (mag > peak) peak = mag;
         end
         env = lowpass(peak > env ? attack : release_c, env, peak);
         tgt = 24'd8388608;
         if (env > thresh) begin
            ir = iratio > 17'd65536 ? 64'd65536 : 64'(iratio);
            num = (64'(thresh) << 16) + 64'(env - thresh) * ir;
            tgt = 24'((num << 7) / 64'(env));
         end
         sgain = lowpass(smooth, sgain, tgt);
         fgain = (64'(sgain) * 64'(makeup) + 64'd32768) >> 16;
         for (int c = 0; c < n; c++) begin
            s = smp[c*24 +: 24];
            mag = s < 0 ? -s : s;
            r = (64'(mag) * fgain + 64'd4194304) >> 23;
            if (s < 0) o[c*24 +: 24] = r > 64'd8388608 ? 24'h800000 : 24'(-r);
            else       o[c*24 +: 24] = r > 64'd8388607 ? 24'h7fffff : 24'(r);
         end
      end
      gained_q.push_back(o);
      last_q.push_back(lst);
   endfunction

   function void check_result(logic [191:0] d, logic lst);
      logic [191:0] e;
      logic         exp_l;
      if (gained_q.size() == 0) begin
         report("response with nothing expected", 0, d[23:0], '0);
         return;
      end
      e = gained_q.pop_front();
      exp_l = last_q.pop_front();
      for (int c = 0; c < 8; c++)
         if (d[c*24 +: 24] !== e[c*24 +: 24])
            report("out_ch mismatch", c, d[c*24 +: 24], e[c*24 +: 24]);
      if (lst !== exp_l) report("out_last mismatch", 8, {23'd0, lst}, {23'd0, exp_l});
   endfunction

   function void report(string what, int fld, logic [23:0] got, logic [23:0] exp);
      $display("ERROR %0t: %s field %0d got %h expected %h", $time, what, fld, got, exp);
      errors++;
   endfunction
endclass

module tb_channel_linked_peak_compressor;
   import clpc_pkg::*;

   logic clock = 0, reset = 1;
   logic req_tvalid = 0, req_tlast = 0, rsp_tready = 0;
   logic [191:0] req_tdata = '0;
   wire  req_tready, rsp_tvalid, rsp_tlast;
   wire  [191:0] rsp_tdata;
   logic csr_we = 0;
   logic [2:0] csr_index = '0;
   logic [23:0] csr_data = '0;
   frame_scoreboard sb;
   int cycles = 0, sent = 0, got = 0;

   channel_linked_peak_compressor u_dut (.*);

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > 1000000) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // responder: random stalls per response
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_result(rsp_tdata, rsp_tlast);
         got++;
      end
   end

   task automatic write_csr(logic [2:0] idx, logic [23:0] val);
      req_tvalid <= 1'b0;
      @(posedge clock);
      csr_we <= 1; csr_index <= idx; csr_data <= val;
      @(posedge clock);
      csr_we <= 0;
      sb.write_reg(idx, val);
   endtask

   task automatic send_frame(logic [191:0] d, logic lst);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1; req_tdata <= d; req_tlast <= lst;
      do @(posedge clock); while (!req_tready);
      sb.note_request(d, lst);
      sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (got < sent) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   function automatic logic [23:0] loud_sample();
      case ($urandom_range(0, 5))
         0: return 24'h800000;
         1: return 24'h7fffff;
         2: return 24'(-$urandom_range(0, 2000));
         default: return 24'($urandom);
      endcase
   endfunction

   task automatic random_frames(int count);
      logic [191:0] d;
      for (int i = 0; i < count; i++) begin
         for (int c = 0; c < 8; c++) d[c*24 +: 24] = loud_sample();
         send_frame(d, 1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      sb = new();
      sb.reset_state();
      repeat (4) @(posedge clock);
      reset <= 0;

      // directed: extremes at reset settings
      send_frame({8{24'h800000}}, 1'b1);
      send_frame({8{24'h7fffff}}, 1'b0);
      send_frame('0, 1'b1);
      send_frame({8{24'hffffff}}, 1'b0);
      drain();
      // hard compression, large makeup to force clipping
      write_csr(REG_CH_COUNT, 24'd8);
      write_csr(REG_THRESH, 24'd0);
      write_csr(REG_IRATIO, 24'd0);
      write_csr(REG_ATTACK, 24'd0);
      write_csr(REG_RELEASE, 24'hffffff);
      write_csr(REG_SMOOTH, 24'd0);
      write_csr(REG_MAKEUP, 24'hffffff);
      send_frame({8{24'h800000}}, 1'b1);
      send_frame({24'h000001, {7{24'h7fffff}}}, 1'b0);
      send_frame('0, 1'b1);
      drain();
      // inv_ratio above unity, threshold above full scale, odd channel counts
      write_csr(REG_IRATIO, 24'h01ffff);
      write_csr(REG_CH_COUNT, 24'd0);
      send_frame({8{24'h400000}}, 1'b0);
      drain();
      write_csr(REG_CH_COUNT, 24'd15);
      write_csr(REG_THRESH, 24'hffffff);
      send_frame({8{24'h800000}}, 1'b1);
      drain();
      write_csr(REG_ENABLE, 24'd0);
      write_csr(REG_CH_COUNT, 24'd3);
      send_frame({8{24'h812345}}, 1'b1);
      drain();
      write_csr(REG_ENABLE, 24'd1);

      for (int ph = 0; ph < 12; ph++) begin
         drain();
         write_csr(REG_ENABLE, {23'd0, ph % 5 != 4});
         write_csr(REG_CH_COUNT, 24'($urandom_range(0, 15)));
         if ($urandom_range(0, 2) == 0) write_csr(REG_THRESH, 24'(ph * 700000));
         else write_csr(REG_THRESH, 24'($urandom_range(0, 8388608)));
         write_csr(REG_IRATIO, 24'($urandom_range(0, 131071)));
         write_csr(REG_ATTACK, ph == 0 ? 24'd0 : 24'($urandom));
         write_csr(REG_RELEASE, ph == 1 ? 24'hffffff : 24'($urandom));
         write_csr(REG_SMOOTH, $urandom_range(0, 1) ? 24'($urandom)
                                                    : 24'($urandom_range(0, 4096)));
         write_csr(REG_MAKEUP, $urandom_range(0, 1) ? 24'($urandom)
                                                    : 24'($urandom_range(0, 200000)));
         random_frames(106);
      end
      drain();
      $display("Covered %0d frames over 12 random register settings plus directed extremes.",
               sent);
      if (sb.errors == 0 && sb.gained_q.size() == 0 && got == sent)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end
endmodule
